>>> hdl/tre_pkg.sv
package tre_pkg;

    localparam int RegCount = 32;
    localparam int RegAddrW = $clog2(RegCount);
    localparam int XLen     = 32;

    localparam logic [RegAddrW-1:0] PrintIdxReg = RegAddrW'(11);
    localparam logic [RegAddrW-1:0] PrintValReg = RegAddrW'(12);
    localparam logic [RegAddrW-1:0] ZeroReg     = '0;

    typedef enum logic [6:0] {
        OP_ADD   = 7'd1,
        OP_ADDI  = 7'd2,
        OP_BEQ   = 7'd3,
        OP_BLTU  = 7'd4,
        OP_PRINT = 7'd5,
        OP_JUMP  = 7'd6,
        OP_LI    = 7'd7,
        OP_LUI   = 7'd8,
        OP_MV    = 7'd9
    } opcode_t;

    typedef struct packed {
        logic [31:0] instruction;
    } instr_beat_t;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic        halted;
        logic        print_valid;
        logic [31:0] print_index;
        logic [31:0] print_value;
    } result_beat_t;

    function automatic logic [XLen-1:0] sext_imm12(input logic [31:0] w);
        return {{(XLen-12){w[31]}}, w[31:20]};
    endfunction

    function automatic logic [XLen-1:0] jump_offset(input logic [31:0] w);
        return {{(XLen-21){w[31]}}, w[31:12], 1'b0};
    endfunction

endpackage

>>> hdl/tre_if.sv
interface tre_instr_if
    import tre_pkg::*;
;
    logic        valid;
    logic        ready;
    instr_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tre_result_if
    import tre_pkg::*;
;
    logic         valid;
    logic         ready;
    result_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/tiny_risc_instruction_executor_top.sv
// an accepted instruction beat passes the decode stage and then the result
// register to its result beat; one instruction per cycle unless result.ready
// stalls, with two register file reads at decode, one write, one-deep bypass
// reset: pc, halt flag and all registers read as zero; register file entries
// are cleared at once through per-entry valid bits
module tiny_risc_instruction_executor_top
    import tre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tre_instr_if.sink    instr,
    tre_result_if.source result
);

    // register file storage and per-entry valid bits
    logic [XLen-1:0]     rf_mem [RegCount];
    logic [RegCount-1:0] rf_vld_reg;

    // decode stage
    logic                s1_valid_reg;
    logic [31:0]         s1_instr_reg;
    logic [XLen-1:0]     rda_reg;
    logic [XLen-1:0]     rdb_reg;
    logic                rda_vld_reg;
    logic                rdb_vld_reg;
    logic [RegAddrW-1:0] ra_addr_reg;
    logic [RegAddrW-1:0] rb_addr_reg;

    // bypass of the last register write
    logic                byp_vld_reg;
    logic [RegAddrW-1:0] byp_addr_reg;
    logic [XLen-1:0]     byp_data_reg;

    // architectural state
    logic [XLen-1:0]     pc_reg, pc_next;
    logic                stopped_reg, stopped_next;
    logic [XLen-1:0]     r11_reg, r12_reg;

    // result register
    logic                out_valid_reg;
    result_beat_t        out_data_reg, out_data_next;

    logic                in_accept;
    logic                s1_go;
    opcode_t             in_op;
    logic [RegAddrW-1:0] ra_addr;
    logic [RegAddrW-1:0] rb_addr;

    opcode_t             ex_op;
    logic [RegAddrW-1:0] ex_rd;
    logic [XLen-1:0]     opa;
    logic [XLen-1:0]     opb;
    logic [XLen-1:0]     br_imm;
    logic [XLen-1:0]     br_target;
    logic                wr_en;
    logic [RegAddrW-1:0] wr_addr;
    logic [XLen-1:0]     wr_data;
    logic                wr_commit;

    assign s1_go          = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready    = !s1_valid_reg || s1_go;
    assign in_accept      = instr.valid && instr.ready;
    assign result.valid   = out_valid_reg;
    assign result.data    = out_data_reg;

    // port a reads rd for branches, rs2 otherwise; port b always reads rs1
    assign in_op   = opcode_t'(instr.data.instruction[6:0]);
    assign rb_addr = instr.data.instruction[16:12];
    assign ra_addr = (in_op == OP_BEQ || in_op == OP_BLTU)
                     ? instr.data.instruction[11:7]
                     : instr.data.instruction[21:17];

    always_ff @(posedge clk)
    begin
        if (wr_commit)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        if (in_accept)
        begin
            rda_reg <= rf_mem[ra_addr];
            rdb_reg <= rf_mem[rb_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_instr_reg <= instr.data.instruction;
            ra_addr_reg  <= ra_addr;
            rb_addr_reg  <= rb_addr;
        end
        if (wr_commit)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_data;
        end
        if (s1_go)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rda_vld_reg   <= 1'b0;
            rdb_vld_reg   <= 1'b0;
            byp_vld_reg   <= 1'b0;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            r11_reg       <= '0;
            r12_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                rda_vld_reg  <= rf_vld_reg[ra_addr];
                rdb_vld_reg  <= rf_vld_reg[rb_addr];
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_commit)
            begin
                rf_vld_reg[wr_addr] <= 1'b1;
                byp_vld_reg         <= 1'b1;
                if (wr_addr == PrintIdxReg)
                begin
                    r11_reg <= wr_data;
                end
                if (wr_addr == PrintValReg)
                begin
                    r12_reg <= wr_data;
                end
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
                pc_reg        <= pc_next;
                stopped_reg   <= stopped_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand fetch with bypass of a write that raced the read
    always_comb
    begin
        if (byp_vld_reg && byp_addr_reg == ra_addr_reg)
        begin
            opa = byp_data_reg;
        end
        else
        begin
            opa = rda_vld_reg ? rda_reg : '0;
        end
        if (byp_vld_reg && byp_addr_reg == rb_addr_reg)
        begin
            opb = byp_data_reg;
        end
        else
        begin
            opb = rdb_vld_reg ? rdb_reg : '0;
        end
    end

    assign ex_op     = opcode_t'(s1_instr_reg[6:0]);
    assign ex_rd     = s1_instr_reg[11:7];
    assign br_imm    = sext_imm12(s1_instr_reg);
    assign br_target = pc_reg + {br_imm[XLen-2:0], 1'b0};
    assign wr_addr   = ex_rd;
    assign wr_commit = s1_go && wr_en && (wr_addr != ZeroReg);

    always_comb
    begin
        pc_next       = pc_reg;
        stopped_next  = stopped_reg;
        wr_en         = 1'b0;
        wr_data       = '0;
        out_data_next = '0;
        if (!stopped_reg)
        begin
            pc_next = pc_reg + XLen'(4);
            unique case (ex_op)
                OP_ADD:
                begin
                    wr_en   = 1'b1;
                    wr_data = opb + opa;
                end
                OP_ADDI:
                begin
                    wr_en   = 1'b1;
                    wr_data = opb + sext_imm12(s1_instr_reg);
                end
                OP_BEQ:
                begin
                    if (opa == opb)
                    begin
                        pc_next = br_target;
                    end
                end
                OP_BLTU:
                begin
                    if (opa < opb)
                    begin
                        pc_next = br_target;
                    end
                end
                OP_PRINT:
                begin
                    out_data_next.print_valid = 1'b1;
                    out_data_next.print_index = r11_reg;
                    out_data_next.print_value = r12_reg;
                end
                OP_JUMP:
                begin
                    pc_next = pc_reg + jump_offset(s1_instr_reg);
                end
                OP_LI:
                begin
                    wr_en   = 1'b1;
                    wr_data = sext_imm12(s1_instr_reg);
                end
                OP_LUI:
                begin
                    wr_en   = 1'b1;
                    wr_data = {s1_instr_reg[31:12], 12'h000};
                end
                OP_MV:
                begin
                    wr_en   = 1'b1;
                    wr_data = opb;
                end
                default:
                begin
                    stopped_next = 1'b1;
                    pc_next      = pc_reg;
                end
            endcase
        end
        out_data_next.fetch_address = pc_next;
        out_data_next.halted        = stopped_next;
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halt flag cleared without reset");

    a_zero_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_vld_reg[0])
        else $error("register zero was written");

    a_pc_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_go |=> $stable(pc_reg))
        else $error("pc moved without an executed instruction");

    a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !wr_commit)
        else $error("register write while halted");

    a_halt_no_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.halted |-> !out_data_reg.print_valid)
        else $error("print reported together with halt");

endmodule
